// ===== hdl/bmt_pkg.sv =====
// Shared types, opcodes and constants of the breakpoint match table.
package bmt_pkg;
  localparam int ENTRIES = 16;
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int EW = 65;

  typedef enum logic [3:0] {
    OP_CHECK = 4'd0, OP_ADD = 4'd1, OP_REM_ADDR = 4'd2, OP_REM_SLOT = 4'd3,
    OP_EN_SLOT = 4'd4, OP_EN_ADDR = 4'd5, OP_Q_ADDR = 4'd6, OP_Q_SLOT = 4'd7,
    OP_STEP = 4'd8, OP_SOFT_AT = 4'd9, OP_TCHECK = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_DUP = 2'd1, ST_FULL = 2'd2, ST_NONE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SOFT_OFF = 2'd0, SOFT_ANY = 2'd1, SOFT_AT = 2'd2
  } soft_t;

  typedef struct packed {
    logic [31:0] addr;
    logic        on;
    logic [15:0] skip;
    logic [15:0] hits;
  } entry_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_SCAN = 6'b000010, S_ACT = 6'b000100,
    S_MOVE = 6'b001000, S_READ = 6'b010000, S_OUT = 6'b100000
  } state_t;
endpackage

// ===== hdl/breakpoint_match_table.sv =====
// Top level of the breakpoint match table: sequencer around one entry memory.
// An item reads the entries one per cycle: a search, then for a removal the compaction
// of the entries behind the hit; the result is then registered and out_valid raised.
// One item at a time: in_ready stays low until the last result has been taken.
// Reset (rst, synchronous) empties the table and disarms the soft stop; the memory
// itself is not cleared.
module breakpoint_match_table import bmt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  opcode,
  input  logic [31:0] address,
  input  logic [3:0]  slot,
  input  logic [15:0] ignore_count,
  input  logic        enable_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        stop,
  output logic        found,
  output logic        entry_enabled,
  output logic        conditional,
  output logic [31:0] entry_address,
  output logic [15:0] entry_ignore,
  output logic [4:0]  entry_total,
  output logic [1:0]  status
);
  state_t      state;
  logic [3:0]  op;
  logic [31:0] a;
  logic [3:0]  sl;
  logic [15:0] sk;
  logic        en;
  logic [CW-1:0] used;
  soft_t       soft_mode;
  logic [31:0] soft_addr;
  logic [CW-1:0] idx;
  logic [CW-1:0] pos;
  logic        hit;
  logic        we;
  logic [IW-1:0] waddr, raddr;
  entry_t      wdata, rdata;
  logic        slot_ok;
  logic        rd_pend;
  logic        scan_hit;

  bmt_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign slot_ok = (CW'(sl) < used);
  assign scan_hit = (state == S_SCAN) && rd_pend && !hit && (rdata.addr == a);

  always_comb begin
    raddr = scan_hit ? IW'(idx - CW'(1)) : idx[IW-1:0];
    we = 1'b0;
    waddr = pos[IW-1:0];
    wdata = rdata;
    if (state == S_ACT) begin
      unique case (op)
        OP_ADD: begin
          waddr = used[IW-1:0];
          wdata = '{addr: a, on: 1'b1, skip: sk, hits: 16'd0};
          we = !hit && (used < CW'(ENTRIES));
        end
        OP_CHECK, OP_TCHECK: begin
          we = hit && rdata.on;
          if ({1'b0, rdata.hits} + 17'd1 > {1'b0, rdata.skip}) wdata.hits = 16'd0;
          else wdata.hits = rdata.hits + 16'd1;
        end
        OP_EN_SLOT, OP_EN_ADDR: begin
          we = hit;
          wdata.on = en;
        end
        default: ;
      endcase
    end else if (state == S_MOVE && rd_pend) begin
      we = 1'b1;
      waddr = IW'(idx - CW'(2));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      used <= '0;
      soft_mode <= SOFT_OFF;
      soft_addr <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          op <= opcode; a <= address; sl <= slot; sk <= ignore_count; en <= enable_value;
          idx <= '0; hit <= 1'b0; rd_pend <= 1'b0;
          {stop, found, entry_enabled, conditional} <= '0;
          entry_address <= '0; entry_ignore <= '0; status <= ST_OK;
          unique case (opcode)
            OP_REM_SLOT, OP_EN_SLOT, OP_Q_SLOT: state <= S_READ;
            OP_STEP: begin soft_mode <= SOFT_ANY; state <= S_OUT; end
            OP_SOFT_AT: begin soft_mode <= SOFT_AT; soft_addr <= address; state <= S_OUT; end
            OP_CHECK: begin
              if (soft_mode == SOFT_ANY || (soft_mode == SOFT_AT && soft_addr == address)) begin
                soft_mode <= SOFT_OFF; stop <= 1'b1; state <= S_OUT;
              end else state <= S_SCAN;
            end
            OP_ADD, OP_REM_ADDR, OP_EN_ADDR, OP_Q_ADDR, OP_TCHECK: state <= S_SCAN;
            default: state <= S_OUT;
          endcase
        end
        S_READ: begin
          idx <= CW'(sl);
          hit <= slot_ok;
          pos <= CW'(sl);
          if (!slot_ok) begin status <= ST_NONE; state <= S_OUT; end
          else rd_pend <= 1'b1;
          if (slot_ok) state <= S_SCAN;
        end
        S_SCAN: begin
          if (rd_pend && (hit || rdata.addr == a)) begin
            hit <= 1'b1;
            if (!hit) pos <= idx - CW'(1);
            state <= S_ACT;
            idx <= (hit ? pos : idx - CW'(1));
          end else if (idx >= used) begin
            state <= S_ACT;
          end else begin
            rd_pend <= 1'b1;
            idx <= idx + CW'(1);
          end
        end
        S_ACT: begin
          state <= S_OUT;
          unique case (op)
            OP_ADD: begin
              if (hit) status <= ST_DUP;
              else if (used >= CW'(ENTRIES)) status <= ST_FULL;
              else used <= used + CW'(1);
            end
            OP_CHECK, OP_TCHECK:
              stop <= hit && rdata.on &&
                      ({1'b0, rdata.hits} + 17'd1 > {1'b0, rdata.skip});
            OP_EN_SLOT, OP_EN_ADDR: if (!hit) status <= ST_NONE;
            OP_Q_ADDR, OP_Q_SLOT: begin
              if (!hit) status <= ST_NONE;
              else begin
                found <= 1'b1; entry_enabled <= rdata.on;
                conditional <= rdata.skip != 16'd0;
                entry_address <= rdata.addr; entry_ignore <= rdata.skip;
              end
            end
            OP_REM_ADDR, OP_REM_SLOT: begin
              if (!hit) status <= ST_NONE;
              else begin
                idx <= pos + CW'(1); rd_pend <= 1'b0; state <= S_MOVE;
              end
            end
            default: ;
          endcase
        end
        S_MOVE: begin
          if (idx >= used) begin
            used <= used - CW'(1);
            state <= S_OUT;
          end else begin
            rd_pend <= 1'b1;
            idx <= idx + CW'(1);
          end
        end
        S_OUT: begin
          entry_total <= 5'(used);
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) used <= CW'(ENTRIES))
    else $error("entry count overflow");
  assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("accept while result pending");
  assert property (@(posedge clk) disable iff (rst) we |-> state == S_ACT || state == S_MOVE)
    else $error("stray memory write");
endmodule

// ===== hdl/bmt_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
module bmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
